// File: design/spi_ras_pkg.sv
`default_nettype none
package spi_ras_pkg;

   // input function codes (req_tuser)
   localparam logic [1:0] FUNC_READ  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_RX    = 2'd2;

   // result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NO_ECHO   = 3'd1;
   localparam logic [2:0] ST_NO_STATUS = 3'd2;
   localparam logic [2:0] ST_NO_HEADER = 3'd3;
   localparam logic [2:0] ST_BUSY      = 3'd4;

   // CSR indexes
   localparam logic CSR_CRC_ENABLE  = 1'b0;
   localparam logic CSR_RETRY_LIMIT = 1'b1;

   // SPI command codes
   localparam logic [7:0] CMD_READ_INT  = 8'hC4;
   localparam logic [7:0] CMD_READ_EXT  = 8'hCA;
   localparam logic [7:0] CMD_WRITE_INT = 8'hC3;
   localparam logic [7:0] CMD_WRITE_EXT = 8'hC9;

   localparam logic [23:0] ADDR_CLOCKLESS_MAX = 24'h000010;
   localparam logic [23:0] ADDR_INTERNAL_MAX  = 24'h0000FF;
   localparam logic [6:0]  CRC7_INIT          = 7'h7F;
   localparam logic [6:0]  CRC7_POLY          = 7'h09;
   localparam logic [7:0]  HDR_MASK           = 8'hF0;
   localparam logic [3:0]  RETRY_RESET        = 4'd10;

   typedef enum logic [5:0] {
      PH_IDLE    = 6'b000001,
      PH_ECHO    = 6'b000010,
      PH_STATUS  = 6'b000100,
      PH_HEADER  = 6'b001000,
      PH_DATA    = 6'b010000,
      PH_CRCDROP = 6'b100000
   } phase_type;

   // result payload, first member in the top bits
   typedef struct packed {
      logic [1:0]  pad;
      logic [31:0] read_data;
      logic [2:0]  status;
      logic        done_res;
      logic        select_active;
      logic        expect_rx;
      logic [7:0]  tx_byte;
   } rsp_payload_type;

   // microcode
   typedef enum logic [3:0] {
      SRC_CODE, SRC_A23, SRC_A15, SRC_A7,
      SRC_W31, SRC_W23, SRC_W15, SRC_W7,
      SRC_PAD, SRC_CRC
   } src_type;

   typedef enum logic [2:0] {
      COND_NEVER, COND_ALWAYS, COND_INTERNAL, COND_EXTERNAL,
      COND_READ, COND_CRC_OFF
   } cond_type;

   typedef struct packed {
      src_type    src;
      logic       emit;
      cond_type   cond;
      logic [3:0] target;
      logic       stop;
   } seq_word_type;

   typedef struct packed {
      logic        go;
      logic [23:0] addr;
      logic [31:0] wdata;
      logic        is_write;
      logic        crc_en;
   } seq_start_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] tx_byte;
      logic       last;
   } seq_emit_type;

   function automatic logic [7:0] cmd_code(logic is_write, logic internal);
      logic [7:0] c;
      if (is_write) c = internal ? CMD_WRITE_INT : CMD_WRITE_EXT;
      else          c = internal ? CMD_READ_INT  : CMD_READ_EXT;
      return c;
   endfunction

   function automatic logic [6:0] crc7_step(logic [6:0] crc, logic [7:0] b);
      logic [6:0] c;
      logic       fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[6] ^ b[i];
         c = {c[5:0], 1'b0};
         if (fb) c = c ^ CRC7_POLY;
      end
      return c;
   endfunction

   // command builder program
   function automatic seq_word_type seq_rom(logic [3:0] step);
      seq_word_type w;
      case (step)
         4'd0:    w = '{SRC_CODE, 1'b1, COND_INTERNAL, 4'd2,  1'b0};
         4'd1:    w = '{SRC_A23,  1'b1, COND_NEVER,    4'd0,  1'b0};
         4'd2:    w = '{SRC_A15,  1'b1, COND_NEVER,    4'd0,  1'b0};
         4'd3:    w = '{SRC_A7,   1'b1, COND_READ,     4'd8,  1'b0};
         4'd4:    w = '{SRC_W31,  1'b1, COND_NEVER,    4'd0,  1'b0};
         4'd5:    w = '{SRC_W23,  1'b1, COND_NEVER,    4'd0,  1'b0};
         4'd6:    w = '{SRC_W15,  1'b1, COND_NEVER,    4'd0,  1'b0};
         4'd7:    w = '{SRC_W7,   1'b1, COND_ALWAYS,   4'd10, 1'b0};
         4'd8:    w = '{SRC_PAD,  1'b0, COND_EXTERNAL, 4'd10, 1'b0};
         4'd9:    w = '{SRC_PAD,  1'b1, COND_NEVER,    4'd0,  1'b0};
         4'd10:   w = '{SRC_PAD,  1'b0, COND_CRC_OFF,  4'd12, 1'b0};
         4'd11:   w = '{SRC_CRC,  1'b1, COND_NEVER,    4'd0,  1'b0};
         default: w = '{SRC_PAD,  1'b0, COND_NEVER,    4'd0,  1'b1};
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

// File: design/spi_ras_cmd_seq.sv
`default_nettype none
module spi_ras_cmd_seq
   import spi_ras_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire seq_start_type start,
   input  wire logic          advance,
   output logic               busy,
   output seq_emit_type       emit
);

   logic        run_ff, run_in;
   logic [3:0]  step_ff, step_in;
   logic        pend_valid_ff, pend_valid_in;
   logic [7:0]  pend_byte_ff, pend_byte_in;
   logic [6:0]  crc_ff, crc_in;
   logic [23:0] addr_ff;
   logic [31:0] wdata_ff;
   logic        write_ff, crc_en_ff, internal_ff, clockless_ff;

   seq_word_type word;
   logic [7:0]   new_byte;
   logic         jump;
   logic         fire;

   assign word = seq_rom(step_ff);
   assign fire = run_ff && advance;

   always_comb begin
      case (word.src)
         SRC_CODE: new_byte = cmd_code(write_ff, internal_ff);
         SRC_A23:  new_byte = addr_ff[23:16];
         SRC_A15:  new_byte = addr_ff[15:8] | {clockless_ff, 7'b0};
         SRC_A7:   new_byte = addr_ff[7:0];
         SRC_W31:  new_byte = wdata_ff[31:24];
         SRC_W23:  new_byte = wdata_ff[23:16];
         SRC_W15:  new_byte = wdata_ff[15:8];
         SRC_W7:   new_byte = wdata_ff[7:0];
         SRC_CRC:  new_byte = {crc_ff, 1'b0};
         default:  new_byte = 8'h00;
      endcase
   end

   always_comb begin
      case (word.cond)
         COND_ALWAYS:   jump = 1'b1;
         COND_INTERNAL: jump = internal_ff;
         COND_EXTERNAL: jump = !internal_ff;
         COND_READ:     jump = !write_ff;
         COND_CRC_OFF:  jump = !crc_en_ff;
         default:       jump = 1'b0;
      endcase
   end

   // each byte is held back until the next byte or the stop step so the final one can carry last
   always_comb begin
      run_in        = run_ff;
      step_in       = step_ff;
      pend_valid_in = pend_valid_ff;
      pend_byte_in  = pend_byte_ff;
      crc_in        = crc_ff;
      emit          = '0;
      if (start.go) begin
         run_in        = 1'b1;
         step_in       = 4'd0;
         pend_valid_in = 1'b0;
         crc_in        = CRC7_INIT;
      end else if (fire) begin
         step_in = jump ? word.target : step_ff + 4'd1;
         if (word.emit) begin
            pend_byte_in  = new_byte;
            pend_valid_in = 1'b1;
            crc_in        = crc7_step(crc_ff, new_byte);
            emit.valid    = pend_valid_ff;
            emit.tx_byte  = pend_byte_ff;
         end
         if (word.stop) begin
            run_in        = 1'b0;
            pend_valid_in = 1'b0;
            emit.valid    = 1'b1;
            emit.tx_byte  = pend_byte_ff;
            emit.last     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff        <= 1'b0;
         step_ff       <= 4'd0;
         pend_valid_ff <= 1'b0;
      end else begin
         run_ff        <= run_in;
         step_ff       <= step_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_byte_ff <= pend_byte_in;
      crc_ff       <= crc_in;
      if (start.go) begin
         addr_ff      <= start.addr;
         wdata_ff     <= start.wdata;
         write_ff     <= start.is_write;
         crc_en_ff    <= start.crc_en;
         internal_ff  <= (start.addr <= ADDR_INTERNAL_MAX);
         clockless_ff <= (start.addr <= ADDR_CLOCKLESS_MAX);
      end
   end

   assign busy = run_ff;

endmodule
`default_nettype wire

// File: design/spi_register_access_sequencer.sv
`default_nettype none
// Channel   Dir  Handshake            Payload
// req_      in   req_tvalid/tready    tuser func, tdata reg_addr/write_data/rx_byte
// rsp_      out  rsp_tvalid/tready    tuser tx_valid, tdata result fields, tlast last
// csr_      in   csr_valid/ready      csr_index, csr_data
//
// Start item: after the accept, the command builder walks its microcode, one step per cycle,
// 7 to 11 steps (4 to 9 byte results); req_tready stays low while it runs.
// Received-byte items go straight to the parser on accept.
// Every step and every accept waits for a free result register.
// Reset (synchronous): parser idle, crc_enable 1, retry_limit 10.
module spi_register_access_sequencer
   import spi_ras_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // func
   input  wire logic [63:0] req_tdata,   // reg_addr[23:0], write_data[55:24], rx_byte[63:56]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic             rsp_tuser,   // tx_valid
   output logic [47:0]      rsp_tdata,   // tx_byte, expect_rx, select_active, done_res,
                                         // status, read_data, pad
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [3:0]  csr_data
);

   // configuration
   logic       crc_enable_ff;
   logic [3:0] retry_limit_ff;

   // response parser state
   phase_type   phase_ff, phase_in;
   logic [3:0]  retries_ff, retries_in;
   logic [7:0]  command_code_ff, command_code_in;
   logic        is_read_ff, is_read_in;
   logic        is_clockless_ff, is_clockless_in;
   logic [2:0]  byte_count_ff, byte_count_in;
   logic [31:0] data_accum_ff, data_accum_in;

   // result register
   logic            rsp_valid_ff;
   logic            rsp_user_ff;
   logic            rsp_last_ff;
   rsp_payload_type rsp_payload_ff;

   logic            out_free;
   logic            accept;
   logic            seq_busy;
   seq_start_type   seq_start;
   seq_emit_type    seq_emit;

   logic            res_valid;
   rsp_payload_type res;

   logic [23:0] in_addr;
   logic [31:0] in_wdata;
   logic [7:0]  in_rx;
   logic [2:0]  count_next;
   logic [31:0] accum_next;

   assign in_addr  = req_tdata[23:0];
   assign in_wdata = req_tdata[55:24];
   assign in_rx    = req_tdata[63:56];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !seq_busy && out_free;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign count_next = byte_count_ff + 3'd1;

   always_comb begin
      accum_next = data_accum_ff;
      case (byte_count_ff[1:0])
         2'd0:    accum_next[7:0]   = data_accum_ff[7:0]   | in_rx;
         2'd1:    accum_next[15:8]  = data_accum_ff[15:8]  | in_rx;
         2'd2:    accum_next[23:16] = data_accum_ff[23:16] | in_rx;
         default: accum_next[31:24] = data_accum_ff[31:24] | in_rx;
      endcase
   end

   always_comb begin
      phase_in        = phase_ff;
      retries_in      = retries_ff;
      command_code_in = command_code_ff;
      is_read_in      = is_read_ff;
      is_clockless_in = is_clockless_ff;
      byte_count_in   = byte_count_ff;
      data_accum_in   = data_accum_ff;
      seq_start       = '0;
      seq_start.addr     = in_addr;
      seq_start.wdata    = in_wdata;
      seq_start.is_write = (req_tuser == FUNC_WRITE);
      seq_start.crc_en   = crc_enable_ff;
      res_valid       = 1'b0;
      // default shape: keep waiting for the next received byte
      res               = '0;
      res.expect_rx     = 1'b1;
      res.select_active = 1'b1;

      if (accept) begin
         case (req_tuser)
            FUNC_READ, FUNC_WRITE: begin
               if (phase_ff != PH_IDLE) begin
                  res_valid    = 1'b1;
                  res.done_res = 1'b1;
                  res.status   = ST_BUSY;
               end else begin
                  seq_start.go    = 1'b1;
                  command_code_in = cmd_code(req_tuser == FUNC_WRITE,
                                             in_addr <= ADDR_INTERNAL_MAX);
                  is_read_in      = (req_tuser == FUNC_READ);
                  is_clockless_in = (in_addr <= ADDR_CLOCKLESS_MAX);
                  byte_count_in   = 3'd0;
                  data_accum_in   = 32'd0;
                  retries_in      = retry_limit_ff;
                  phase_in        = PH_ECHO;
               end
            end
            FUNC_RX: begin
               res_valid = (phase_ff != PH_IDLE);
               case (phase_ff)
                  PH_ECHO, PH_STATUS, PH_HEADER: begin
                     if ((phase_ff == PH_ECHO && in_rx == command_code_ff) ||
                         (phase_ff == PH_STATUS && in_rx == 8'h00) ||
                         (phase_ff == PH_HEADER && (in_rx & HDR_MASK) == HDR_MASK)) begin
                        retries_in = retry_limit_ff;
                        if (phase_ff == PH_ECHO) begin
                           phase_in = PH_STATUS;
                        end else if (phase_ff == PH_HEADER) begin
                           phase_in      = PH_DATA;
                           byte_count_in = 3'd0;
                           data_accum_in = 32'd0;
                        end else if (is_read_ff) begin
                           phase_in = PH_HEADER;
                        end else begin
                           // write acknowledged by zero status
                           phase_in          = PH_IDLE;
                           res.expect_rx     = 1'b0;
                           res.select_active = 1'b0;
                           res.done_res      = 1'b1;
                        end
                     end else if (retries_ff == 4'd0) begin
                        phase_in          = PH_IDLE;
                        res.expect_rx     = 1'b0;
                        res.select_active = 1'b0;
                        res.done_res      = 1'b1;
                        if (phase_ff == PH_ECHO)        res.status = ST_NO_ECHO;
                        else if (phase_ff == PH_STATUS) res.status = ST_NO_STATUS;
                        else                            res.status = ST_NO_HEADER;
                     end else begin
                        retries_in = retries_ff - 4'd1;
                     end
                  end
                  PH_DATA: begin
                     data_accum_in = accum_next;
                     byte_count_in = count_next;
                     if (count_next >= 3'd4) begin
                        if (is_clockless_ff) begin
                           phase_in      = PH_CRCDROP;
                           byte_count_in = 3'd0;
                        end else begin
                           phase_in          = PH_IDLE;
                           res.expect_rx     = 1'b0;
                           res.select_active = 1'b0;
                           res.done_res      = 1'b1;
                           res.read_data     = accum_next;
                        end
                     end
                  end
                  PH_CRCDROP: begin
                     byte_count_in = count_next;
                     if (count_next >= 3'd2) begin
                        phase_in          = PH_IDLE;
                        res.expect_rx     = 1'b0;
                        res.select_active = 1'b0;
                        res.done_res      = 1'b1;
                        res.read_data     = data_accum_ff;
                     end
                  end
                  default: ;  // idle: byte ignored
               endcase
            end
            default: ;  // unused function code
         endcase
      end
   end

   spi_ras_cmd_seq u_cmd_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (seq_start),
      .advance (out_free),
      .busy    (seq_busy),
      .emit    (seq_emit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         retries_ff      <= 4'd0;
         command_code_ff <= 8'd0;
         is_read_ff      <= 1'b0;
         is_clockless_ff <= 1'b0;
         byte_count_ff   <= 3'd0;
         data_accum_ff   <= 32'd0;
         crc_enable_ff   <= 1'b1;
         retry_limit_ff  <= RETRY_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         retries_ff      <= retries_in;
         command_code_ff <= command_code_in;
         is_read_ff      <= is_read_in;
         is_clockless_ff <= is_clockless_in;
         byte_count_ff   <= byte_count_in;
         data_accum_ff   <= data_accum_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CRC_ENABLE:  crc_enable_ff  <= csr_data[0];
               CSR_RETRY_LIMIT: retry_limit_ff <= csr_data;
               default: ;
            endcase
         end
         if (seq_emit.valid || res_valid) rsp_valid_ff <= 1'b1;
         else if (rsp_tready)             rsp_valid_ff <= 1'b0;
      end
   end

   // result payload: command bytes from the builder, else parser results
   always_ff @(posedge clock) begin
      if (seq_emit.valid) begin
         rsp_user_ff    <= 1'b1;
         rsp_last_ff    <= seq_emit.last;
         rsp_payload_ff <= '{pad: 2'b00, read_data: 32'd0, status: ST_OK, done_res: 1'b0,
                             select_active: 1'b1, expect_rx: seq_emit.last,
                             tx_byte: seq_emit.tx_byte};
      end else if (res_valid) begin
         rsp_user_ff    <= 1'b0;
         rsp_last_ff    <= 1'b1;
         rsp_payload_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = rsp_payload_ff;

endmodule
`default_nettype wire

// File: design/spi_ras_checker.sv
`default_nettype none
module spi_ras_checker
   import spi_ras_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic        rsp_tuser,
   input wire logic [47:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   rsp_payload_type p;
   assign p = rsp_tdata;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   // a finishing result closes its transaction
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && p.done_res |-> rsp_tlast && !rsp_tuser)
      else $error("done result not last or carries tx byte");

   // error codes only on finishing results
   a_status_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && p.status != ST_OK |-> p.done_res)
      else $error("status without done");

   // read data only on a successful finish
   a_data_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && p.read_data != 32'd0 |-> p.done_res && p.status == ST_OK)
      else $error("read data outside ok finish");

endmodule

bind spi_register_access_sequencer spi_ras_checker u_spi_ras_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

// File: tb/tb_spi_register_access_sequencer.sv
`default_nettype none
module tb_spi_register_access_sequencer;
   import spi_ras_pkg::*;

   // function code that the block must ignore
   localparam logic [1:0]  FUNC_NONE     = 2'd3;
   // internal clockless addresses carry this flag in their 16-bit form
   localparam logic [15:0] CLOCKLESS_BIT = 16'h8000;
   // receiver back-pressure burst: starts after this many results, lasts this long
   localparam int RECV_HOLD_AT  = 20;
   localparam int HOLD_CYCLES   = 150;
   // quiet cycles after the last result (ignored items leave no trace)
   localparam int SETTLE_CYCLES = 8;
   // watchdog: cycles with no transaction on any channel
   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_PER_SEGMENT = 13;

   typedef enum {IDLE_SENDER_LIGHT, IDLE_SENDER_HEAVY, IDLE_NONE} idle_plan_type;

   // one result transaction, fields by name
   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        expect_rx;
      logic        select_active;
      logic        done_res;
      logic [2:0]  status;
      logic [31:0] read_data;
      logic        last;
   } seq_result_type;

   // Tracks the command builder and the response parser; every accepted request
   // turns into the result transactions it must produce.
   class sequencer_scoreboard;
      seq_result_type pending[$];
      phase_type   phase;
      logic [3:0]  retries_left;
      logic [7:0]  cmd;
      logic        reading;
      logic        clockless;
      logic [2:0]  byte_cnt;
      logic [31:0] accum;
      logic        crc_on;
      logic [3:0]  retry_max;
      int          errors;
      int          results_seen;

      function new();
         phase        = PH_IDLE;
         retries_left = '0;
         cmd          = '0;
         reading      = 1'b0;
         clockless    = 1'b0;
         byte_cnt     = '0;
         accum        = '0;
         crc_on       = 1'b1;
         retry_max    = RETRY_RESET;
         errors       = 0;
         results_seen = 0;
      endfunction

      function void set_register(logic idx, logic [3:0] val);
         if (idx == CSR_CRC_ENABLE) crc_on = val[0];
         else retry_max = val;
      endfunction

      function void add_result(logic txv, logic [7:0] txb, logic more, logic sel,
                               logic done, logic [2:0] st, logic [31:0] rd, logic lst);
         seq_result_type r;
         r = '{txv, txb, more, sel, done, st, rd, lst};
         pending.push_back(r);
      endfunction

      function void finish_txn(logic [2:0] st, logic [31:0] rd);
         phase = PH_IDLE;
         add_result(1'b0, 8'h00, 1'b0, 1'b0, 1'b1, st, rd, 1'b1);
      endfunction

      function void keep_waiting();
         add_result(1'b0, 8'h00, 1'b1, 1'b1, 1'b0, ST_OK, 32'h0, 1'b1);
      endfunction

      // wrong byte in a wait phase: burn one retry or give up
      function void wait_miss(logic [2:0] fail_code);
         if (retries_left == 4'd0) finish_txn(fail_code, 32'h0);
         else begin
            retries_left = retries_left - 4'd1;
            keep_waiting();
         end
      endfunction

      function logic [6:0] crc7_next(logic [6:0] crc, logic [7:0] b);
         for (int i = 7; i >= 0; i--)
            crc = {crc[5:0], 1'b0} ^ ((crc[6] ^ b[i]) ? CRC7_POLY : 7'h00);
         return crc;
      endfunction

      function void note_request(logic [1:0] func, logic [23:0] addr, logic [31:0] wdata,
                                 logic [7:0] rx);
         logic [7:0]  cmd_bytes[$];
         logic [15:0] short_addr;
         logic [6:0]  crc;
         logic        internal;
         if (func == FUNC_NONE) return;
         if (func == FUNC_READ || func == FUNC_WRITE) begin
            if (phase != PH_IDLE) begin
               // rejected, running transaction untouched
               add_result(1'b0, 8'h00, 1'b1, 1'b1, 1'b1, ST_BUSY, 32'h0, 1'b1);
               return;
            end
            internal  = addr <= ADDR_INTERNAL_MAX;
            clockless = addr <= ADDR_CLOCKLESS_MAX;
            reading   = func == FUNC_READ;
            if (reading) cmd = internal ? CMD_READ_INT : CMD_READ_EXT;
            else cmd = internal ? CMD_WRITE_INT : CMD_WRITE_EXT;
            cmd_bytes.push_back(cmd);
            if (internal) begin
               short_addr = addr[15:0] | (clockless ? CLOCKLESS_BIT : 16'h0000);
               cmd_bytes.push_back(short_addr[15:8]);
               cmd_bytes.push_back(short_addr[7:0]);
            end else begin
               cmd_bytes.push_back(addr[23:16]);
               cmd_bytes.push_back(addr[15:8]);
               cmd_bytes.push_back(addr[7:0]);
            end
            if (!reading) begin
               cmd_bytes.push_back(wdata[31:24]);
               cmd_bytes.push_back(wdata[23:16]);
               cmd_bytes.push_back(wdata[15:8]);
               cmd_bytes.push_back(wdata[7:0]);
            end else if (internal) cmd_bytes.push_back(8'h00);
            if (crc_on) begin
               crc = CRC7_INIT;
               foreach (cmd_bytes[i]) crc = crc7_next(crc, cmd_bytes[i]);
               cmd_bytes.push_back({crc, 1'b0});
            end
            byte_cnt     = '0;
            accum        = '0;
            retries_left = retry_max;
            phase        = PH_ECHO;
            foreach (cmd_bytes[i])
               add_result(1'b1, cmd_bytes[i], i == cmd_bytes.size() - 1, 1'b1, 1'b0, ST_OK,
                          32'h0, i == cmd_bytes.size() - 1);
            return;
         end
         case (phase)
            PH_ECHO: begin
               if (rx == cmd) begin
                  phase        = PH_STATUS;
                  retries_left = retry_max;
                  keep_waiting();
               end else wait_miss(ST_NO_ECHO);
            end
            PH_STATUS: begin
               if (rx == 8'h00) begin
                  if (reading) begin
                     phase        = PH_HEADER;
                     retries_left = retry_max;
                     keep_waiting();
                  end else finish_txn(ST_OK, 32'h0);
               end else wait_miss(ST_NO_STATUS);
            end
            PH_HEADER: begin
               if ((rx & HDR_MASK) == HDR_MASK) begin
                  phase    = PH_DATA;
                  byte_cnt = '0;
                  accum    = '0;
                  keep_waiting();
               end else wait_miss(ST_NO_HEADER);
            end
            PH_DATA: begin
               accum    = accum | ({24'h0, rx} << (8 * byte_cnt[1:0]));
               byte_cnt = byte_cnt + 3'd1;
               if (byte_cnt >= 3'd4) begin
                  if (clockless) begin
                     phase    = PH_CRCDROP;
                     byte_cnt = '0;
                     keep_waiting();
                  end else finish_txn(ST_OK, accum);
               end else keep_waiting();
            end
            PH_CRCDROP: begin
               byte_cnt = byte_cnt + 3'd1;
               if (byte_cnt >= 3'd2) finish_txn(ST_OK, accum);
               else keep_waiting();
            end
            default: ; // received byte with nothing open: dropped
         endcase
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(logic txv, rsp_payload_type p, logic lst);
         seq_result_type want;
         results_seen++;
         if (pending.size() == 0) begin
            $error("unexpected result: tx_valid %0b tx_byte %h done_res %0b status %0d",
                   txv, p.tx_byte, p.done_res, p.status);
            errors++;
            return;
         end
         want = pending.pop_front();
         check_field("tx_valid", want.tx_valid, txv);
         check_field("tx_byte", want.tx_byte, p.tx_byte);
         check_field("expect_rx", want.expect_rx, p.expect_rx);
         check_field("select_active", want.select_active, p.select_active);
         check_field("done_res", want.done_res, p.done_res);
         check_field("status", want.status, p.status);
         check_field("read_data", want.read_data, p.read_data);
         check_field("last", want.last, lst);
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser   = FUNC_NONE;
   logic [63:0] req_tdata   = '0;   // reg_addr, write_data, rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic        rsp_tuser;          // tx_valid
   logic [47:0] rsp_tdata;          // rsp_payload_type
   logic        rsp_tlast;
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic        csr_index   = CSR_CRC_ENABLE;
   logic [3:0]  csr_data    = '0;

   sequencer_scoreboard sb = new();

   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;
   int        stall_cycles  = 0;
   // wait phase that the current random transaction is meant to fail in
   phase_type doomed_phase  = PH_IDLE;

   spi_register_access_sequencer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog: any transaction on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_spi_register_access_sequencer: done, errors");
         $finish;
      end
   end

   // Result side: check each accepted transaction, then pick the next tready.
   // One long hold-off lets the block back up into its request port.
   initial begin
      bit held;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tuser, rsp_tdata, rsp_tlast);
         if (!held && sb.results_seen >= RECV_HOLD_AT) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic set_idling(idle_plan_type plan);
      case (plan)
         IDLE_SENDER_LIGHT: begin
            send_idle_pct = 11;
            recv_idle_pct = 51;
         end
         IDLE_SENDER_HEAVY: begin
            send_idle_pct = 51;
            recv_idle_pct = 11;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
   endtask

   // Offer one request, with random gaps ahead of it; returns once accepted.
   task automatic send_item(logic [1:0] f, logic [23:0] a, logic [31:0] w, logic [7:0] r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {r, w, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(f, a, w, r);
   endtask

   // Stop offering, let every expected result arrive, then let ignored items settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Both registers back to back; valid stays up between the two writes.
   task automatic write_config(logic crc_en, logic [3:0] retries);
      csr_valid <= 1'b1;
      csr_index <= CSR_CRC_ENABLE;
      csr_data  <= {3'b000, crc_en};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_register(CSR_CRC_ENABLE, {3'b000, crc_en});
      csr_index <= CSR_RETRY_LIMIT;
      csr_data  <= retries;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_register(CSR_RETRY_LIMIT, retries);
      csr_valid <= 1'b0;
   endtask

   // clockless, internal and external classes equally often
   function automatic logic [23:0] pick_address();
      case ($urandom_range(2))
         0:       return 24'($urandom_range(ADDR_CLOCKLESS_MAX));
         1:       return 24'($urandom_range(ADDR_INTERNAL_MAX, ADDR_CLOCKLESS_MAX + 1));
         default: return 24'($urandom_range(24'hFFFFFF, ADDR_INTERNAL_MAX + 1));
      endcase
   endfunction

   // Mostly well-formed exchanges: the right echo, status and header with some
   // stray bytes in between; a share of transactions is forced to time out in
   // one wait phase. Sprinkled in: busy starts, ignored codes, bytes with no
   // transaction open.
   task automatic drive_random(int count);
      int         sent;
      logic [1:0] f;
      logic [7:0] r;
      logic       miss;
      sent = 0;
      while (sent < count) begin
         f    = FUNC_RX;
         r    = 8'($urandom_range(255));
         miss = (sb.phase == doomed_phase) || ($urandom_range(99) < 20);
         if ($urandom_range(99) < 3) f = FUNC_NONE;
         else if (sb.phase == PH_IDLE) begin
            if ($urandom_range(99) >= 10) begin
               f = $urandom_range(1) ? FUNC_WRITE : FUNC_READ;
               case ($urandom_range(5))
                  0:       doomed_phase = PH_ECHO;
                  1:       doomed_phase = PH_STATUS;
                  2:       doomed_phase = PH_HEADER;
                  default: doomed_phase = PH_IDLE;
               endcase
            end
         end else if ($urandom_range(99) < 5)
            f = $urandom_range(1) ? FUNC_WRITE : FUNC_READ;
         else begin
            case (sb.phase)
               PH_ECHO: begin
                  if (!miss) r = sb.cmd;
                  else while (r == sb.cmd) r = 8'($urandom_range(255));
               end
               PH_STATUS: r = miss ? 8'($urandom_range(255, 1)) : 8'h00;
               PH_HEADER: r = miss ? {4'($urandom_range(14)), r[3:0]} : (r | HDR_MASK);
               default: ; // data and trailing CRC bytes are arbitrary
            endcase
         end
         if (f != FUNC_NONE && !(f == FUNC_RX && sb.phase == PH_IDLE)) sent++;
         send_item(f, pick_address(), $urandom, r);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      set_idling(IDLE_SENDER_LIGHT);

      // --- directed, reset register values (CRC on, 10 retries) ---
      send_item(FUNC_RX, 24'hFFFFFF, 32'hFFFFFFFF, 8'hFF);    // byte with nothing open
      send_item(FUNC_NONE, 24'h000000, 32'h00000000, 8'h00);  // unused function code
      // clockless read at the top of its class: stray byte, echo, busy start,
      // status, header, data, two dropped CRC bytes
      send_item(FUNC_READ, ADDR_CLOCKLESS_MAX, 32'h0, 8'h00);
      send_item(FUNC_RX, 24'h0, 32'h0, 8'h00);
      send_item(FUNC_RX, 24'h0, 32'h0, CMD_READ_INT);
      send_item(FUNC_WRITE, 24'h000200, 32'h12345678, 8'h00);
      send_item(FUNC_RX, 24'h0, 32'h0, 8'h00);
      send_item(FUNC_RX, 24'h0, 32'h0, 8'hF5);
      send_item(FUNC_RX, 24'h0, 32'h0, 8'h01);
      send_item(FUNC_RX, 24'h0, 32'h0, 8'h80);
      send_item(FUNC_RX, 24'h0, 32'h0, 8'hFF);
      send_item(FUNC_RX, 24'h0, 32'h0, 8'h7E);
      send_item(FUNC_RX, 24'h0, 32'h0, 8'hA5);
      send_item(FUNC_RX, 24'h0, 32'h0, 8'h5A);
      // widest external write
      send_item(FUNC_WRITE, 24'hFFFFFF, 32'hFFFFFFFF, 8'h00);
      send_item(FUNC_RX, 24'h0, 32'h0, CMD_WRITE_EXT);
      send_item(FUNC_RX, 24'h0, 32'h0, 8'h00);
      // first plain internal address: header miss, then a bare 0xF0 header
      send_item(FUNC_READ, ADDR_CLOCKLESS_MAX + 24'd1, 32'h0, 8'h00);
      send_item(FUNC_RX, 24'h0, 32'h0, CMD_READ_INT);
      send_item(FUNC_RX, 24'h0, 32'h0, 8'h00);
      send_item(FUNC_RX, 24'h0, 32'h0, 8'h0F);
      send_item(FUNC_RX, 24'h0, 32'h0, HDR_MASK);
      send_item(FUNC_RX, 24'h0, 32'h0, 8'hEF);
      send_item(FUNC_RX, 24'h0, 32'h0, 8'hBE);
      send_item(FUNC_RX, 24'h0, 32'h0, 8'hAD);
      send_item(FUNC_RX, 24'h0, 32'h0, 8'hDE);

      // --- random segments, each under its own register setting ---
      for (int seg = 0; seg < 6; seg++) begin
         drain();
         case (seg)
            0:       write_config(1'b0, 4'd0);
            1:       write_config(1'b1, 4'd15);
            2:       write_config(1'b0, 4'd15);
            3:       write_config(1'b1, 4'd0);
            4:       write_config(1'b1, 4'd5);
            default: write_config(1'b0, 4'd2);
         endcase
         if (seg < 2) set_idling(IDLE_SENDER_LIGHT);
         else if (seg < 4) set_idling(IDLE_SENDER_HEAVY);
         else set_idling(IDLE_NONE);
         drive_random(RANDOM_PER_SEGMENT);
      end

      drain();
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("tb_spi_register_access_sequencer: done, clean");
      else
         $display("tb_spi_register_access_sequencer: done, errors");
      $finish;
   end

endmodule
`default_nettype wire

// File: files.f
design/spi_ras_pkg.sv
design/spi_ras_cmd_seq.sv
design/spi_register_access_sequencer.sv
design/spi_ras_checker.sv
tb/tb_spi_register_access_sequencer.sv
